/* rtl/core/acfr_pkg.sv */
// ----------------------------------------------------------------------------
// acfr_pkg
// shared widths, types and codes for the arc centre from radius core
// ----------------------------------------------------------------------------
package acfr_pkg;

    localparam int unsigned FracBits  = 16;
    localparam int unsigned CoordW    = 24;
    localparam int unsigned DispW     = CoordW + 1;
    // q = 4 r^2 - d2 fits in 50 bits for the operand ranges
    localparam int unsigned SqW       = 50;
    // root of an SqW-bit value with FracBits fraction bits
    localparam int unsigned RootW     = SqW / 2 + FracBits;
    localparam int unsigned RootSteps = RootW;
    // quotient s * 2^F / h, h >= 2^F, so the quotient has RootW bits
    localparam int unsigned QuoW      = RootW;
    localparam int unsigned QuoSteps  = RootW + FracBits;
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoAw    = 2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_DISP  = 2'd1,
        ST_RADIUS_LOW = 2'd2
    } t_status;

    // classified request handed from the front part to the back part
    typedef struct packed {
        logic signed [DispW-1:0] x;
        logic signed [DispW-1:0] y;
        logic [SqW-1:0]          q;
        logic [SqW-1:0]          d2;
        logic                    neg;
        t_status                 status;
    } t_req;

    // one step of a restoring square root with two bits brought down
    typedef struct packed {
        logic [RootW+1:0] rem;
        logic [RootW-1:0] root;
    } t_sqrt;

    function automatic t_sqrt sqrt_step(t_sqrt cur, logic [1:0] pair);
        t_sqrt            nxt;
        logic [RootW+1:0] r2;
        logic [RootW+1:0] trial;
        r2    = {cur.rem[RootW-1:0], pair};
        trial = {cur.root, 2'b01};
        if (r2 >= trial) begin
            nxt.rem  = r2 - trial;
            nxt.root = {cur.root[RootW-2:0], 1'b1};
        end else begin
            nxt.rem  = r2;
            nxt.root = {cur.root[RootW-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

/* rtl/core/acfr_front.sv */
// ----------------------------------------------------------------------------
// acfr_front
// forms displacements and exact squares, classifies the request
// ----------------------------------------------------------------------------
module acfr_front import acfr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [CoordW-1:0] i_cur_a,
    input  logic signed [CoordW-1:0] i_cur_b,
    input  logic signed [CoordW-1:0] i_tgt_a,
    input  logic signed [CoordW-1:0] i_tgt_b,
    input  logic signed [CoordW-1:0] i_radius,
    input  logic                     i_cw,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_req                     o_req
);

    // stage 1: displacements
    logic                    r_v1;
    logic signed [DispW-1:0] r_x1, r_y1;
    logic signed [CoordW-1:0] r_r1;
    logic                    r_cw1;
    // stage 2: squares
    logic                    r_v2;
    logic signed [DispW-1:0] r_x2, r_y2;
    logic [2*DispW-1:0]      r_xx, r_yy;
    logic [2*CoordW-1:0]     r_rr;
    logic                    r_neg2;
    // stage 3: classified
    logic                    r_v3;
    t_req                    r_req;

    logic en3, en2, en1;
    assign en3 = !r_v3 || i_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_req   = r_req;

    logic [SqW+1:0] d2_w, rr4_w;
    assign d2_w  = (SqW+2)'(r_xx) + (SqW+2)'(r_yy);
    assign rr4_w = (SqW+2)'({r_rr, 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_x1  <= DispW'(i_tgt_a) - DispW'(i_cur_a);
            r_y1  <= DispW'(i_tgt_b) - DispW'(i_cur_b);
            r_r1  <= i_radius;
            r_cw1 <= i_cw;
        end
        if (en2) begin
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_xx   <= $unsigned((2*DispW)'(r_x1) * (2*DispW)'(r_x1));
            r_yy   <= $unsigned((2*DispW)'(r_y1) * (2*DispW)'(r_y1));
            r_rr   <= $unsigned((2*CoordW)'(r_r1) * (2*CoordW)'(r_r1));
            // k starts negative; ccw flips, negative radius flips again
            r_neg2 <= r_cw1 ^ r_r1[CoordW-1];
        end
        if (en3) begin
            r_req.x   <= r_x2;
            r_req.y   <= r_y2;
            r_req.neg <= r_neg2;
            r_req.d2  <= SqW'(d2_w);
            r_req.q   <= SqW'(rr4_w - d2_w);
            if (r_x2 == '0 && r_y2 == '0)
                r_req.status <= ST_ZERO_DISP;
            else if (rr4_w < d2_w)
                r_req.status <= ST_RADIUS_LOW;
            else
                r_req.status <= ST_OK;
        end
    end

endmodule

/* rtl/core/acfr_fifo.sv */
// ----------------------------------------------------------------------------
// acfr_fifo
// short queue between the front and the back part
// ----------------------------------------------------------------------------
module acfr_fifo import acfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_req o_data
);

    t_req              r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wp, r_rp;
    logic [FifoAw:0]   r_cnt;
    logic              wr, rd;

    assign o_ready = r_cnt != (FifoAw+1)'(FifoDepth);
    assign o_valid = r_cnt != '0;
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FifoAw+1)'(wr) - (FifoAw+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

/* rtl/core/acfr_back.sv */
// ----------------------------------------------------------------------------
// acfr_back
// pipelined square roots, divider and final offset products
// ----------------------------------------------------------------------------
module acfr_back import acfr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_req                     i_req,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [CoordW-1:0] o_ofs_a,
    output logic signed [CoordW-1:0] o_ofs_b,
    output t_status                  o_status
);

    localparam int unsigned SqrtN = RootSteps;
    localparam int unsigned DivN  = QuoSteps;
    localparam int unsigned NSt   = SqrtN + DivN + 4;
    localparam int unsigned ProdW = DispW + QuoW + 1;
    localparam int unsigned NumW  = ProdW + 1;

    typedef struct packed {
        logic signed [DispW-1:0] x;
        logic signed [DispW-1:0] y;
        logic                    neg;
        t_status                 status;
    } t_side;

    // whole pipe advances together; stall only while a full output is not taken
    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    logic  r_v    [NSt];
    t_side r_side [NSt];

    // root lanes: one digit per stage
    t_sqrt          r_sq [SqrtN+1];
    t_sqrt          r_sh [SqrtN+1];
    logic [SqW-1:0] r_qv [SqrtN+1];
    logic [SqW-1:0] r_hv [SqrtN+1];

    // divider lane: one quotient bit per stage
    logic [RootW:0]   r_rem [DivN+1];
    logic [RootW-1:0] r_s   [DivN+1];
    logic [RootW-1:0] r_h   [DivN+1];
    logic [QuoW-1:0]  r_quo [DivN+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSt; i++) r_v[i] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < NSt; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= '{x: i_req.x, y: i_req.y, neg: i_req.neg,
                           status: i_req.status};
            for (int i = 1; i < NSt; i++) r_side[i] <= r_side[i-1];
        end
    end

    // roots: stage 0 loads, stage i performs digit i-1
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0] <= '0;
            r_sh[0] <= '0;
            r_qv[0] <= i_req.q;
            r_hv[0] <= i_req.d2;
            for (int i = 1; i <= SqrtN; i++) begin
                // pair index counts down from RootW-FracBits-1; fractional digits bring zeros
                if ((RootW - i) >= FracBits) begin
                    r_sq[i] <= sqrt_step(r_sq[i-1],
                        r_qv[i-1][2*(RootW-i-FracBits) +: 2]);
                    r_sh[i] <= sqrt_step(r_sh[i-1],
                        r_hv[i-1][2*(RootW-i-FracBits) +: 2]);
                end else begin
                    r_sq[i] <= sqrt_step(r_sq[i-1], 2'b00);
                    r_sh[i] <= sqrt_step(r_sh[i-1], 2'b00);
                end
                r_qv[i] <= r_qv[i-1];
                r_hv[i] <= r_hv[i-1];
            end
        end
    end

    // long division of s * 2^F by h, msb first
    always_ff @(posedge i_clk) begin
        logic [RootW:0] t;
        if (adv) begin
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_s[0]   <= r_sq[SqrtN].root;
            r_h[0]   <= r_sh[SqrtN].root;
            for (int i = 1; i <= DivN; i++) begin
                if (DivN - i >= FracBits)
                    t = {r_rem[i-1][RootW-1:0], r_s[i-1][DivN-i-FracBits]};
                else
                    t = {r_rem[i-1][RootW-1:0], 1'b0};
                if (t >= {1'b0, r_h[i-1]}) begin
                    r_rem[i] <= t - {1'b0, r_h[i-1]};
                    r_quo[i] <= {r_quo[i-1][QuoW-2:0], 1'b1};
                end else begin
                    r_rem[i] <= t;
                    r_quo[i] <= {r_quo[i-1][QuoW-2:0], 1'b0};
                end
                r_s[i] <= r_s[i-1];
                r_h[i] <= r_h[i-1];
            end
        end
    end

    // products then sums then scaling with saturation
    localparam int unsigned PS = SqrtN + DivN + 2;
    logic signed [QuoW:0]   ks;
    logic signed [ProdW-1:0] r_yk, r_xk;
    logic signed [NumW-1:0]  r_na, r_nb;
    t_side sp, sn;
    assign sp = r_side[PS-1];
    assign sn = r_side[PS];
    assign ks = sp.neg ? -$signed({1'b0, r_quo[DivN]}) : $signed({1'b0, r_quo[DivN]});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_yk <= ProdW'(sp.y * ks);
            r_xk <= ProdW'(sp.x * ks);
            r_na <= (NumW'(sn.x) <<< FracBits) - NumW'(r_yk);
            r_nb <= (NumW'(sn.y) <<< FracBits) + NumW'(r_xk);
        end
    end

    function automatic logic signed [CoordW-1:0] finish(logic signed [NumW-1:0] n);
        logic [NumW-1:0] mag;
        mag = n[NumW-1] ? NumW'(-n) : NumW'(n);
        mag = mag >> (FracBits + 1);
        if (n[NumW-1])
            return (mag > NumW'(24'd8388608)) ? CoordW'(24'h800000) : CoordW'(-mag);
        else
            return (mag > NumW'(24'd8388607)) ? CoordW'(24'h7FFFFF) : CoordW'(mag);
    endfunction

    t_side sf;
    assign sf = r_side[NSt-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_v[NSt-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_status <= sf.status;
            if (sf.status == ST_OK) begin
                o_ofs_a <= finish(r_na);
                o_ofs_b <= finish(r_nb);
            end else begin
                o_ofs_a <= '0;
                o_ofs_b <= '0;
            end
        end
    end

    ap_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_ofs_a == '0 && o_ofs_b == '0)
        else $error("error result carries offsets");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ofs_a))
        else $error("stalled result changed");
    ap_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_OK || o_status == ST_ZERO_DISP
                 || o_status == ST_RADIUS_LOW)
        else $error("bad status code");

endmodule

/* rtl/core/arc_center_from_radius_core.sv */
// ----------------------------------------------------------------------------
// arc_center_from_radius_core
// centre offset of a radius-form arc from its start point
// ----------------------------------------------------------------------------
// One request beat per clock is taken and one result beat per clock is
// delivered while no stall holds the pipe. A request passes 3 front stages,
// the queue, then a load stage, 41 root stages, a divider load stage, 57
// divide stages (one quotient bit each) and product, sum and output stages.
// The front part squares the displacements and flags zero displacement or a
// radius too small; the back part forms both roots digit by digit and the
// quotient bit by bit in one deep pipeline. Offsets are truncated toward zero
// and saturate to 24 bits; error results carry zeros.
module arc_center_from_radius_core import acfr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // current_a, current_b, target_a, target_b, radius
    input  logic [119:0] s_axis_tdata,
    // clockwise
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // center_offset_a, center_offset_b, status, zero pad
    output logic [55:0]  m_axis_tdata
);

    logic f_valid, f_ready, q_valid, q_ready;
    t_req f_req, q_req;
    logic signed [CoordW-1:0] ofs_a, ofs_b;
    t_status status;

    acfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cur_a  (s_axis_tdata[23:0]),
        .i_cur_b  (s_axis_tdata[47:24]),
        .i_tgt_a  (s_axis_tdata[71:48]),
        .i_tgt_b  (s_axis_tdata[95:72]),
        .i_radius (s_axis_tdata[119:96]),
        .i_cw     (s_axis_tuser),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_req    (f_req)
    );

    acfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_req),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_req)
    );

    acfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_req    (q_req),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_ofs_a  (ofs_a),
        .o_ofs_b  (ofs_b),
        .o_status (status)
    );

    assign m_axis_tdata = {6'b0, status, ofs_b, ofs_a};

endmodule

/* sim/arc_center_from_radius_core_tb.sv */
// ----------------------------------------------------------------------------
// arc_center_from_radius_core_tb
// self-checking bench for the arc centre from radius core
// ----------------------------------------------------------------------------
// Request beats come from a queue filled up front: a short directed set (zero
// displacement, radius too small, exact half-chord radius, saturating offsets,
// both directions and radius signs, coordinate extremes) and then random arcs,
// most of them with a radius large enough to be valid. At each accepted
// request beat the expected offsets and status are computed by an integer
// predictor and queued. Each result beat is compared with the oldest entry.
// Both sides idle and stall in random bursts; the sender once drains the core.
module arc_center_from_radius_core_tb;
    import acfr_pkg::*;

    localparam int      FB        = 16;
    localparam int      NumRandom = 1850;
    localparam int      DrainAt   = 900;
    localparam int      QuietTail = 150;
    localparam longint  CycleMax  = 400000;
    localparam longint  OfsMax    = 8388607;
    localparam longint  OfsMin    = -8388608;

    typedef struct {
        logic signed [23:0] cur_a, cur_b, tgt_a, tgt_b, radius;
        logic               cw;
    } t_arc;

    typedef struct {
        logic signed [23:0] ofs_a, ofs_b;
        t_status            status;
    } t_center;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;

    t_arc    arc_queue[$];
    t_arc    arc_on_bus;
    t_center center_queue[$];
    int      errors;
    int      sent;
    int      send_gap;
    int      recv_stall;
    longint  cycles;

    arc_center_from_radius_core uut (.*);

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // floor(sqrt(v) * 2^FB), digit by digit
    function automatic logic [63:0] root_fixed(logic [63:0] v);
        logic [63:0] rem, root, trial, pair;
        rem  = 0;
        root = 0;
        for (int i = 24 + FB; i >= 0; i--) begin
            pair  = (i >= FB) ? ((v >> (2 * (i - FB))) & 64'd3) : 64'd0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // divide by 2^(FB+1) toward zero and saturate to 24 bits
    function automatic logic signed [23:0] scale_offset(longint num);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = mag >>> (FB + 1);
        if (num < 0)
            return (mag > 8388608) ? 24'(OfsMin) : 24'(-mag);
        return (mag > OfsMax) ? 24'(OfsMax) : 24'(mag);
    endfunction

    function automatic t_center arc_center(t_arc a);
        t_center     c;
        longint      x, y, r, d2, q, ks;
        logic [63:0] s, h, k;
        x = longint'(a.tgt_a) - longint'(a.cur_a);
        y = longint'(a.tgt_b) - longint'(a.cur_b);
        r = longint'(a.radius);
        c.ofs_a  = 0;
        c.ofs_b  = 0;
        c.status = ST_OK;
        if (x == 0 && y == 0) begin
            c.status = ST_ZERO_DISP;
            return c;
        end
        d2 = x * x + y * y;
        q  = 4 * r * r - d2;
        if (q < 0) begin
            c.status = ST_RADIUS_LOW;
            return c;
        end
        s = root_fixed(64'(q));
        h = root_fixed(64'(d2));
        k = (s << FB) / h;
        // k is negative for clockwise, flipped again by a negative radius
        ks = (a.cw ^ (r < 0)) ? -longint'(k) : longint'(k);
        c.ofs_a = scale_offset((x <<< FB) - y * ks);
        c.ofs_b = scale_offset((y <<< FB) + x * ks);
        return c;
    endfunction

    task automatic add_arc(int ca, int cb, int ta, int tb, int r, bit cw);
        t_arc a;
        a.cur_a  = 24'(ca);
        a.cur_b  = 24'(cb);
        a.tgt_a  = 24'(ta);
        a.tgt_b  = 24'(tb);
        a.radius = 24'(r);
        a.cw     = cw;
        arc_queue.push_back(a);
    endtask

    function automatic int clamp24(longint v);
        if (v > OfsMax) return int'(OfsMax);
        if (v < OfsMin) return int'(OfsMin);
        return int'(v);
    endfunction

    function automatic int any24();
        return int'($urandom_range(16777215, 0)) - 8388608;
    endfunction

    task automatic add_random_arc();
        int  ca, cb, ta, tb, r, span, pick;
        longint dx, dy;
        pick = $urandom_range(99, 0);
        case ($urandom_range(9, 0))
            0, 1:    span = 16777215;
            2, 3, 4: span = 65535;
            default: span = 1023;
        endcase
        ca = any24();
        cb = any24();
        ta = clamp24(longint'(ca) + $urandom_range(2 * span, 0) - span);
        tb = clamp24(longint'(cb) + $urandom_range(2 * span, 0) - span);
        dx = longint'(ta) - ca;
        dy = longint'(tb) - cb;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (pick < 3) begin
            // zero displacement
            add_arc(ca, cb, ca, cb, any24(), $urandom_range(1, 0));
        end else if (pick < 12) begin
            // radius below half of the larger axis move is always too small
            r = int'($urandom_range(32'(((dx > dy) ? dx : dy) / 2), 0)) - 1;
            if (r < 0) r = 0;
            add_arc(ca, cb, ta, tb, $urandom_range(1, 0) ? r : -r,
                    $urandom_range(1, 0));
        end else if (pick < 18) begin
            add_arc(any24(), any24(), any24(), any24(), any24(), $urandom_range(1, 0));
        end else begin
            r = clamp24((dx + dy) / 2 + $urandom_range(span, 0));
            add_arc(ca, cb, ta, tb, $urandom_range(1, 0) ? r : -r,
                    $urandom_range(1, 0));
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                center_queue.push_back(arc_center(arc_on_bus));
                sent <= sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end else if (sent + int'(s_axis_tvalid && s_axis_tready) == DrainAt &&
                             center_queue.size() != 0) begin
                    // hold off until the core has emptied
                    s_axis_tvalid <= 1'b0;
                end else if (arc_queue.size() != 0) begin
                    arc_on_bus    = arc_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {arc_on_bus.radius, arc_on_bus.tgt_b, arc_on_bus.tgt_a,
                                      arc_on_bus.cur_b, arc_on_bus.cur_a};
                    s_axis_tuser  <= arc_on_bus.cw;
                    if (arc_queue.size() > QuietTail && $urandom_range(7, 0) == 0)
                        send_gap <= $urandom_range(11, 1);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_center want;
        t_center got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.ofs_a  = m_axis_tdata[23:0];
                got.ofs_b  = m_axis_tdata[47:24];
                got.status = t_status'(m_axis_tdata[49:48]);
                if (center_queue.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got a=%0d b=%0d st=%0d",
                             $time, got.ofs_a, got.ofs_b, got.status);
                    errors++;
                end else begin
                    want = center_queue.pop_front();
                    if (got.ofs_a !== want.ofs_a) begin
                        $display("%0t: offset_a expected %0d actual %0d",
                                 $time, want.ofs_a, got.ofs_a);
                        errors++;
                    end
                    if (got.ofs_b !== want.ofs_b) begin
                        $display("%0t: offset_b expected %0d actual %0d",
                                 $time, want.ofs_b, got.ofs_b);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                m_axis_tready <= 1'b0;
                recv_stall    <= recv_stall - 1;
            end else if (arc_queue.size() > QuietTail && $urandom_range(7, 0) == 0) begin
                m_axis_tready <= 1'b0;
                recv_stall    <= $urandom_range(10, 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleMax) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        errors        = 0;
        sent          = 0;
        cycles        = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;

        // zero displacement, at the origin and at the extremes
        add_arc(0, 0, 0, 0, 100, 1);
        add_arc(-8388608, 8388607, -8388608, 8388607, -8388608, 0);
        // radius zero and radius too small
        add_arc(0, 0, 10, 0, 0, 1);
        add_arc(0, 0, 100, 100, -70, 0);
        // radius exactly half the chord
        add_arc(0, 0, 200, 0, 100, 1);
        add_arc(5, 5, 5, -395, -200, 0);
        // all four direction and radius sign combinations
        add_arc(1000, 2000, 4000, 6000, 5000, 1);
        add_arc(1000, 2000, 4000, 6000, 5000, 0);
        add_arc(1000, 2000, 4000, 6000, -5000, 1);
        add_arc(1000, 2000, 4000, 6000, -5000, 0);
        // tiny chords with the largest radius magnitudes
        add_arc(0, 0, 2, 2, 8388607, 1);
        add_arc(0, 0, 2, 2, 8388607, 0);
        add_arc(0, 0, -2, 2, -8388608, 1);
        add_arc(0, 0, 1, 0, -8388608, 0);
        // coordinate extremes
        add_arc(-8388608, -8388608, 8388607, 8388607, 8388607, 1);
        add_arc(8388607, 8388607, 8388606, 8388607, 8388607, 0);
        add_arc(-8388608, 0, -8388608, 1, -1, 1);
        add_arc(-8388608, -8388608, 0, 0, -8388608, 0);
        add_arc(-4194304, -4194304, 4194304, 4194304, 8388607, 1);
        for (int i = 0; i < NumRandom; i++)
            add_random_arc();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (arc_queue.size() != 0 || s_axis_tvalid || center_queue.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* arc_center_from_radius_core.f */
rtl/core/acfr_pkg.sv
rtl/core/acfr_front.sv
rtl/core/acfr_fifo.sv
rtl/core/acfr_back.sv
rtl/core/arc_center_from_radius_core.sv
sim/arc_center_from_radius_core_tb.sv
